FILE: rtl/ces_pkg.sv
// Shared types, constants and tables of the clamped exponential smoother.
package ces_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // Input kind carried on the tuser lane.
  localparam int MODE_BITS = 2;
  typedef enum logic [MODE_BITS-1:0] {
    MODE_SET_TARGET = 2'd0,
    MODE_ADVANCE    = 2'd1,
    MODE_DEFAULT    = 2'd2,
    MODE_HOLD       = 2'd3
  } ces_mode_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VALUE     = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_VALUE     = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_VALUE = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_CONSTANT = 8'd3;

  // exp(-dt/tau) arithmetic: x = dt/(16*tau) in Q0.32.
  localparam int X_BITS         = 32;
  localparam int SUM_BITS       = X_BITS + 2;
  localparam int DIV_STEPS      = X_BITS;
  localparam int PRE_SHIFT      = 4;
  localparam int FAR_RATIO      = 12;
  localparam int TAYLOR_TERMS   = 12;
  localparam int FIRST_MUL_TERM = 2;
  localparam int SQUARINGS      = 4;
  localparam int CNT_BITS       = $clog2(DIV_STEPS);

  // floor(n/k) == (n * recip(k)) >> RECIP_SHIFT for n < 2^32, 2 <= k <= 12.
  localparam int RECIP_BITS  = 36;
  localparam int RECIP_SHIFT = X_BITS + 4;

  // Blend amount in Q0.16, one extra bit to hold 1.0.
  localparam int AMOUNT_FRAC = 16;
  localparam int AMOUNT_BITS = AMOUNT_FRAC + 1;

  typedef struct packed {
    logic                set_target;
    logic                load_default;
    logic                load_dt;
    logic                snap;
    logic                div_init;
    logic                div_step;
    logic                tay_init;
    logic                tay_mul;
    logic                tay_div;
    logic                tay_sat;
    logic                sq_step;
    logic                amt;
    logic                step_mul;
    logic                step_apply;
    logic                out_load;
    logic [CNT_BITS-1:0] cnt;
  } ces_cmd_t;

  typedef struct packed {
    logic snap_now;
    logic amount_one;
  } ces_status_t;

  // ceil(2^36 / k)
  function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] k);
    logic [RECIP_BITS-1:0] r;
    case (k)
      4'd2:    r = 36'd34359738368;
      4'd3:    r = 36'd22906492246;
      4'd4:    r = 36'd17179869184;
      4'd5:    r = 36'd13743895348;
      4'd6:    r = 36'd11453246123;
      4'd7:    r = 36'd9817068106;
      4'd8:    r = 36'd8589934592;
      4'd9:    r = 36'd7635497416;
      4'd10:   r = 36'd6871947674;
      4'd11:   r = 36'd6247225158;
      4'd12:   r = 36'd5726623062;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/clamped_exponential_smoother_unit.sv
// Top level of the clamped exponential smoother: ports, config registers, sequencer and datapath.
//
// Usage
//   in_*  : one transaction per command. in_tuser is the mode: 0 loads a clamped
//           target, 1 advances time by elapsed_time, 2 loads default_value into
//           value and target, 3 only reports the state.
//   out_* : one transaction per command, carrying value and target afterwards.
//   cfg_* : register writes (min, max, default, time constant); always ready.
//           Write only while no command is in flight.
// Sequencing
//   Modes 0, 2, 3 and a snapping mode 1 go straight to S_OUT (mode 1 by way of S_CHECK).
//   A blending mode 1 runs a 32-step restoring divider for dt/tau, 11 series terms
//   of two multiply steps each, four squarings and the blend multiply, all run one
//   after the other on registered stages.
//   One command at a time; in_tready returns the cycle after the result moves
//   into the output register.
// Reset
//   Synchronous, active low: value and target go to 0, min/max to the full
//   range, default and time constant to 0, output register empty.
// Stall
//   out_tdata holds while out_tready is low; the next command still runs and
//   then waits for the output register to free up.
module clamped_exponential_smoother_unit #(
  parameter int VALUE_WIDTH = ces_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [W-1:0] target_value, [2W-1:W] elapsed_time, zero pad to whole bytes
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,
  // [1:0] mode
  input  logic [ces_pkg::MODE_BITS-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [W-1:0] current_value, [2W-1:W] current_target, zero pad to whole bytes
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ces_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [VALUE_WIDTH-1:0]                cfg_data
);

  localparam int W       = VALUE_WIDTH;
  localparam int TDATA_W = ((2*VALUE_WIDTH+7)/8)*8;

  // Configuration registers
  logic signed [W-1:0] min_r, max_r, def_r;
  logic        [W-1:0] tau_r;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {1'b1, {(W-1){1'b0}}};
      max_r <= {1'b0, {(W-1){1'b1}}};
      def_r <= '0;
      tau_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        ces_pkg::CFG_MIN_VALUE:     min_r <= cfg_data;
        ces_pkg::CFG_MAX_VALUE:     max_r <= cfg_data;
        ces_pkg::CFG_DEFAULT_VALUE: def_r <= cfg_data;
        ces_pkg::CFG_TIME_CONSTANT: tau_r <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Field unpacking
  logic signed [W-1:0] in_target;
  logic        [W-1:0] in_elapsed;
  logic signed [W-1:0] out_value, out_target;

  assign in_target  = in_tdata[W-1:0];
  assign in_elapsed = in_tdata[2*W-1:W];
  assign out_tdata  = TDATA_W'({out_target, out_value});

  ces_pkg::ces_cmd_t    cmd;
  ces_pkg::ces_status_t status;

  ces_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ces_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_target     (in_target),
    .in_elapsed    (in_elapsed),
    .min_value     (min_r),
    .max_value     (max_r),
    .default_value (def_r),
    .time_constant (tau_r),
    .out_value     (out_value),
    .out_target    (out_target)
  );

endmodule

FILE: rtl/ces_ctrl.sv
// Sequencer of the clamped exponential smoother: handshakes and step order.
module ces_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [ces_pkg::MODE_BITS-1:0] in_mode,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  ces_pkg::ces_status_t    status,
  output ces_pkg::ces_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TAY_INIT,
    S_TAY_MUL,
    S_TAY_DIV,
    S_SAT,
    S_SQ,
    S_AMT,
    S_MUL,
    S_APPLY,
    S_OUT
  } state_t;

  localparam int CB = ces_pkg::CNT_BITS;

  state_t          state_r, state_nxt;
  logic [CB-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (ces_pkg::ces_mode_t'(in_mode))
            ces_pkg::MODE_SET_TARGET: begin
              cmd.set_target = 1'b1;
              state_nxt      = S_OUT;
            end
            ces_pkg::MODE_ADVANCE: begin
              cmd.load_dt = 1'b1;
              state_nxt   = S_CHECK;
            end
            ces_pkg::MODE_DEFAULT: begin
              cmd.load_default = 1'b1;
              state_nxt        = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_CHECK: begin
        if (status.snap_now) begin
          cmd.snap  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CB'(1);
        if (cnt_r == CB'(ces_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_TAY_INIT;
        end
      end
      S_TAY_INIT: begin
        cmd.tay_init = 1'b1;
        cnt_nxt      = CB'(ces_pkg::FIRST_MUL_TERM);
        state_nxt    = S_TAY_MUL;
      end
      S_TAY_MUL: begin
        cmd.tay_mul = 1'b1;
        state_nxt   = S_TAY_DIV;
      end
      S_TAY_DIV: begin
        cmd.tay_div = 1'b1;
        if (cnt_r == CB'(ces_pkg::TAYLOR_TERMS)) begin
          state_nxt = S_SAT;
        end else begin
          cnt_nxt   = cnt_r + CB'(1);
          state_nxt = S_TAY_MUL;
        end
      end
      S_SAT: begin
        cmd.tay_sat = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + CB'(1);
        if (cnt_r == CB'(ces_pkg::SQUARINGS - 1)) begin
          state_nxt = S_AMT;
        end
      end
      S_AMT: begin
        cmd.amt   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (status.amount_one) begin
          cmd.snap  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.step_mul = 1'b1;
          state_nxt    = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.step_apply = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/ces_dp.sv
// Datapath of the clamped exponential smoother: state, divider, series, squarer, blend.
module ces_dp #(
  parameter int VALUE_WIDTH = ces_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ces_pkg::ces_cmd_t             cmd,
  output ces_pkg::ces_status_t          status,
  input  logic signed [VALUE_WIDTH-1:0] in_target,
  input  logic        [VALUE_WIDTH-1:0] in_elapsed,
  input  logic signed [VALUE_WIDTH-1:0] min_value,
  input  logic signed [VALUE_WIDTH-1:0] max_value,
  input  logic signed [VALUE_WIDTH-1:0] default_value,
  input  logic        [VALUE_WIDTH-1:0] time_constant,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic signed [VALUE_WIDTH-1:0] out_target
);

  localparam int W  = VALUE_WIDTH;
  localparam int XB = ces_pkg::X_BITS;
  localparam int SB = ces_pkg::SUM_BITS;
  localparam int AF = ces_pkg::AMOUNT_FRAC;
  localparam int AB = ces_pkg::AMOUNT_BITS;
  localparam int RB = ces_pkg::RECIP_BITS;
  localparam int RS = ces_pkg::RECIP_SHIFT;
  localparam logic [SB-1:0]   SUM_ONE   = SB'(1) << XB;
  localparam logic [2*XB-1:0] SQ_HALF   = (2*XB)'(1) << (XB - 1);
  localparam logic [XB:0]     E_HALF    = (XB+1)'(1) << (AF - 1);
  localparam logic [AB-1:0]   AMT_ONE   = AB'(1) << AF;
  localparam logic [W+AF:0]   RND_UP    = (W+AF+1)'(1) << (AF - 1);
  localparam logic [W+AF:0]   RND_DOWN  = RND_UP - (W+AF+1)'(1);
  localparam logic            LAST_SUB  = (ces_pkg::TAYLOR_TERMS % 2) == 1;

  // architectural state
  logic signed [W-1:0] value_r, target_r;
  // working registers
  logic [W-1:0]        dt_r;
  logic [W-1:0]        rem_r;
  logic [XB-1:0]       q_r;
  logic [XB-1:0]       prod_r;
  logic [XB-1:0]       term_r;
  logic [SB-1:0]       sum_r;
  logic [XB-1:0]       e_r;
  logic [AB-1:0]       amount_r;
  logic [W-1:0]        abs_r;
  logic                neg_r;
  logic [W+AF-1:0]     mag_r;
  logic signed [W-1:0] out_value_r, out_target_r;

  // clamp
  logic signed [W-1:0] clamped;
  always_comb begin
    if (in_target < min_value) begin
      clamped = min_value;
    end else if (in_target > max_value) begin
      clamped = max_value;
    end else begin
      clamped = in_target;
    end
  end

  // snap test: zero tau, zero dt or dt >= 12*tau
  logic [W+3:0] tau_far;
  logic         far;
  assign tau_far = (W+4)'(time_constant) * (W+4)'(ces_pkg::FAR_RATIO);
  assign far     = (W+4)'(dt_r) >= tau_far;
  assign status.snap_now   = (time_constant == '0) || (dt_r == '0) || far;
  assign status.amount_one = amount_r[AF];

  // restoring divider, one quotient bit per step
  logic [1:0] pre_idx;
  logic       div_bit;
  logic [W:0] rem_sh, rem_sub;
  logic       rem_ge;
  logic [W-1:0] rem_nxt;
  assign pre_idx = 2'(ces_pkg::PRE_SHIFT - 1) - cmd.cnt[1:0];
  assign div_bit = (cmd.cnt < ces_pkg::CNT_BITS'(ces_pkg::PRE_SHIFT)) ? dt_r[pre_idx] : 1'b0;
  assign rem_sh  = {rem_r, div_bit};
  assign rem_sub = rem_sh - {1'b0, time_constant};
  assign rem_ge  = rem_sh >= {1'b0, time_constant};
  assign rem_nxt = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];

  // Taylor series of exp(-x)
  logic [2*XB-1:0]  tay_prod;
  logic [XB+RB-1:0] tay_quot;
  logic             acc_sub;
  logic [SB-1:0]    sum_acc;
  logic [XB-1:0]    e_sat;
  assign tay_prod = term_r * q_r;
  assign tay_quot = prod_r * ces_pkg::recip(cmd.cnt[3:0]);
  assign acc_sub  = cmd.tay_sat ? LAST_SUB : ~cmd.cnt[0];
  assign sum_acc  = acc_sub ? (sum_r - SB'(term_r)) : (sum_r + SB'(term_r));
  assign e_sat    = (sum_acc[SB-1:XB] != '0) ? '1 : sum_acc[XB-1:0];

  // squaring with rounding
  logic [2*XB-1:0] sq_full;
  assign sq_full = e_r * e_r + SQ_HALF;

  // blend amount and difference
  logic [XB:0]   e_rnd;
  logic [AB-1:0] amount_nxt;
  logic [W:0]    d_tv, d_vt;
  assign e_rnd      = {1'b0, e_r} + E_HALF;
  assign amount_nxt = AMT_ONE - e_rnd[XB:AF];
  assign d_tv       = {target_r[W-1], target_r} - {value_r[W-1], value_r};
  assign d_vt       = {value_r[W-1], value_r} - {target_r[W-1], target_r};

  // step and apply
  logic [W+AF-1:0] mag_prod;
  logic [W+AF:0]   step_full;
  logic [W-1:0]    step;
  assign mag_prod  = abs_r * amount_r[AF-1:0];
  assign step_full = {1'b0, mag_r} + (neg_r ? RND_DOWN : RND_UP);
  assign step      = step_full[W+AF-1:AF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= '0;
      target_r <= '0;
    end else begin
      if (cmd.set_target) begin
        target_r <= clamped;
      end else if (cmd.load_default) begin
        target_r <= default_value;
      end
      if (cmd.load_default) begin
        value_r <= default_value;
      end else if (cmd.snap) begin
        value_r <= target_r;
      end else if (cmd.step_apply) begin
        value_r <= neg_r ? (value_r - $signed(step)) : (value_r + $signed(step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dt) begin
      dt_r <= in_elapsed;
    end
    if (cmd.div_init) begin
      rem_r <= dt_r >> ces_pkg::PRE_SHIFT;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[XB-2:0], rem_ge};
    end
    if (cmd.tay_init) begin
      term_r <= q_r;
      sum_r  <= SUM_ONE - SB'(q_r);
    end else if (cmd.tay_div) begin
      term_r <= tay_quot[XB+RS-1:RS];
    end
    if (cmd.tay_mul) begin
      prod_r <= tay_prod[2*XB-1:XB];
      if (cmd.cnt > ces_pkg::CNT_BITS'(ces_pkg::FIRST_MUL_TERM)) begin
        sum_r <= sum_acc;
      end
    end
    if (cmd.tay_sat) begin
      e_r <= e_sat;
    end else if (cmd.sq_step) begin
      e_r <= sq_full[2*XB-1:XB];
    end
    if (cmd.amt) begin
      amount_r <= amount_nxt;
      neg_r    <= d_tv[W];
      abs_r    <= d_tv[W] ? d_vt[W-1:0] : d_tv[W-1:0];
    end
    if (cmd.step_mul) begin
      mag_r <= mag_prod;
    end
    if (cmd.out_load) begin
      out_value_r  <= value_r;
      out_target_r <= target_r;
    end
  end

  assign out_value  = out_value_r;
  assign out_target = out_target_r;

endmodule

FILE: rtl/ces_chk.sv
// Port-level checker of the clamped exponential smoother and its bind.
module ces_chk #(
  parameter int VALUE_WIDTH = ces_pkg::VALUE_WIDTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [((2*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic [ces_pkg::MODE_BITS-1:0]      in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [ces_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [VALUE_WIDTH-1:0]             cfg_data
);

  // Output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // A stalled result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One command at a time: input closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // Commands other than a time advance go straight to S_OUT and reach an empty output.
  a_quick_modes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && (in_tuser != ces_pkg::MODE_ADVANCE)
    |=> ##1 out_tvalid)
    else $error("fast command result late");

  // A new result is loaded only while the input side is closed.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind clamped_exponential_smoother_unit ces_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_ces_chk (.*);
